[hdl/pup_pkg.sv]
// Shared types and constants of the palette lookup and vertical scaler.
package pup_pkg;

	localparam logic [1:0] OP_PALETTE = 2'd0;
	localparam logic [1:0] OP_PIXEL   = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	typedef struct packed {
		logic [8:0]  dest_x;
		logic [7:0]  dest_y;
		logic [15:0] rgb565;
		logic        two_rows;
	} pup_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} pup_qstat_t;

endpackage

[hdl/pup_front.sv]
// Front end: item intake, palette store, raster tracking and palette read.
module pup_front import pup_pkg::*; #(
	parameter int SRC_WIDTH  = 320,
	parameter int SRC_HEIGHT = 200,
	parameter int DST_HEIGHT = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  color_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  pup_qstat_t  q_stat,
	output logic        push,
	output pup_entry_t  push_entry
);

	localparam int COL_W    = $clog2(SRC_WIDTH);
	localparam int ROW_W    = $clog2(SRC_HEIGHT);
	localparam int QUOT     = DST_HEIGHT / SRC_HEIGHT;
	localparam int REM      = DST_HEIGHT % SRC_HEIGHT;
	localparam int QUOT_LOW = (QUOT >= 2) ? 2 : QUOT;

	logic [15:0]      pal_mem [256];
	logic [255:0]     pal_vld_q;

	logic [COL_W-1:0] column_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0]       first_row_q;
	logic [ROW_W-1:0] acc_q;

	logic             s1_valid_q;
	logic [15:0]      rd_s1;
	logic             vld_s1;
	logic [8:0]       x_s1;
	logic [7:0]       y_s1;
	logic             two_s1;

	logic             accept;
	logic             row_extra;
	logic [1:0]       emit;
	logic [7:0]       row_step;
	logic [ROW_W:0]   acc_sum;
	logic [ROW_W-1:0] acc_next;

	assign src_ready = !s1_valid_q || !q_stat.full;
	assign accept    = src_valid && src_ready;
	assign push      = s1_valid_q && !q_stat.full;

	assign row_extra = acc_q < ROW_W'(REM);
	assign emit      = (QUOT >= 2) ? 2'd2 : (2'(QUOT_LOW) + 2'(row_extra));
	assign row_step  = 8'(QUOT) + 8'(row_extra);
	assign acc_sum   = row_extra ? ({1'b0, acc_q} + (ROW_W+1)'(SRC_HEIGHT - REM))
	                             : ({1'b0, acc_q} - (ROW_W+1)'(REM));
	assign acc_next  = acc_sum[ROW_W-1:0];

	always_ff @(posedge clk) begin
		if (accept && operation == OP_PALETTE) begin
			pal_mem[color_index] <= {red[7:3], green[7:2], blue[7:3]};
		end
		if (accept && operation == OP_PIXEL) begin
			rd_s1  <= pal_mem[color_index];
			vld_s1 <= pal_vld_q[color_index];
			x_s1   <= 9'(column_q);
			y_s1   <= first_row_q;
			two_s1 <= (emit == 2'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q   <= '0;
			column_q    <= '0;
			row_q       <= '0;
			first_row_q <= '0;
			acc_q       <= '0;
			s1_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= (operation == OP_PIXEL) && (emit != 2'd0);
				case (operation)
					OP_PALETTE: begin
						pal_vld_q[color_index] <= 1'b1;
					end
					OP_RESTART: begin
						column_q    <= '0;
						row_q       <= '0;
						first_row_q <= '0;
						acc_q       <= '0;
					end
					OP_PIXEL: begin
						if (column_q == COL_W'(SRC_WIDTH - 1)) begin
							column_q <= '0;
							if (row_q == ROW_W'(SRC_HEIGHT - 1)) begin
								row_q       <= '0;
								first_row_q <= '0;
								acc_q       <= '0;
							end else begin
								row_q       <= row_q + 1'b1;
								first_row_q <= first_row_q + row_step;
								acc_q       <= acc_next;
							end
						end else begin
							column_q <= column_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end else if (push) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		push_entry.dest_x   = x_s1;
		push_entry.dest_y   = y_s1;
		push_entry.rgb565   = vld_s1 ? rd_s1 : 16'd0;
		push_entry.two_rows = two_s1;
	end

endmodule

[hdl/pup_queue.sv]
// Short queue of looked-up pixels between the front end and the back end.
module pup_queue import pup_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pup_entry_t push_entry,
	input  logic       pop,
	output pup_entry_t head,
	output pup_qstat_t q_stat
);

	pup_entry_t      slots [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign head         = slots[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == (Q_AW+1)'(Q_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/pup_back.sv]
// Back end: expands each queued pixel into one or two destination rows.
module pup_back import pup_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pup_entry_t  head,
	input  pup_qstat_t  q_stat,
	output logic        pop,
	output logic        dst_valid,
	input  logic        dst_ready,
	output logic [8:0]  dest_x,
	output logic [7:0]  dest_y,
	output logic [15:0] rgb565,
	output logic        last_of_run
);

	logic        out_valid_q;
	logic        phase_q;
	logic [8:0]  x_q;
	logic [7:0]  y_q;
	logic [15:0] rgb_q;
	logic        last_q;
	logic        load;

	assign load = !out_valid_q || dst_ready;
	assign pop  = load && !q_stat.empty && (phase_q || !head.two_rows);

	assign dst_valid   = out_valid_q;
	assign dest_x      = x_q;
	assign dest_y      = y_q;
	assign rgb565      = rgb_q;
	assign last_of_run = last_q;

	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			x_q    <= head.dest_x;
			rgb_q  <= head.rgb565;
			y_q    <= phase_q ? (head.dest_y + 8'd1) : head.dest_y;
			last_q <= phase_q || !head.two_rows;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_stat.empty;
			if (!q_stat.empty) begin
				phase_q <= !phase_q && head.two_rows;
			end
		end
	end

endmodule

[hdl/palette_upscale_rgb565.sv]
// Top level of the palette lookup and nearest-neighbor vertical scaler.
//
//   channel  direction  handshake             payload
//   source   in         src_valid/src_ready   operation, color_index, red, green, blue
//   result   out        dst_valid/dst_ready   dest_x, dest_y, rgb565, last_of_run
//
// One item is accepted per cycle while the queue has room; a pixel passes the palette
// read register, the queue and the output register before it is offered at the result
// port.
// The single output register gives one result per cycle while dst_ready is high, so a
// pixel of a row mapped to two destination rows takes two results, all others one.
// Reset clears the palette through per-entry valid bits; no clearing pass is needed.
// A stalled result side fills the four-entry queue before the source side stalls.
module palette_upscale_rgb565 import pup_pkg::*; #(
	parameter int SRC_WIDTH  = 320,
	parameter int SRC_HEIGHT = 200,
	parameter int DST_HEIGHT = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  logic [1:0]  operation,
	input  logic [7:0]  color_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        dst_valid,
	input  logic        dst_ready,
	output logic [8:0]  dest_x,
	output logic [7:0]  dest_y,
	output logic [15:0] rgb565,
	output logic        last_of_run
);

	pup_qstat_t q_stat;
	pup_entry_t push_entry;
	pup_entry_t head;
	logic       push;
	logic       pop;

	pup_front #(
		.SRC_WIDTH (SRC_WIDTH),
		.SRC_HEIGHT(SRC_HEIGHT),
		.DST_HEIGHT(DST_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_ready  (src_ready),
		.operation  (operation),
		.color_index(color_index),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	pup_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	pup_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.dst_valid  (dst_valid),
		.dst_ready  (dst_ready),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.rgb565     (rgb565),
		.last_of_run(last_of_run)
	);

`ifndef SYNTHESIS
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> q_stat.full)
		else $error("source stalled while the queue has room");

	a_second_row: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_ready && !last_of_run |=>
		dst_valid && last_of_run && dest_y == $past(dest_y) + 8'd1 &&
		dest_x == $past(dest_x) && rgb565 == $past(rgb565))
		else $error("second destination row does not follow the first");
`endif

endmodule

[dv/palette_upscale_rgb565_test.sv]
// Self-checking testbench of the palette lookup and vertical scaler, with random handshakes.
module palette_upscale_rgb565_test import pup_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SRC_W = 320;
	localparam int SRC_H = 200;
	localparam int DST_H = 240;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [8:0]  dest_x;
		logic [7:0]  dest_y;
		logic [15:0] rgb565;
		logic        last_of_run;
	} scaled_pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        src_valid = 1'b0;
	logic        src_ready;
	logic [1:0]  operation = OP_PIXEL;
	logic [7:0]  color_index = '0;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic        dst_valid;
	logic        dst_ready = 1'b0;
	logic [8:0]  dest_x;
	logic [7:0]  dest_y;
	logic [15:0] rgb565;
	logic        last_of_run;

	logic [15:0]   palette [256];
	int            raster_col;
	int            raster_row;
	int            first_row;
	int            rows_here;
	int            row_acc;
	scaled_pixel_t pixels_due [$];

	int   src_idle_pct = 0;
	int   dst_idle_pct = 0;
	int   mismatches = 0;
	int   stall_cycles = 0;
	int   hold_left = 0;
	logic hold_req = 1'b0;
	logic hold_seen = 1'b0;

	palette_upscale_rgb565 u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_ready   (src_ready),
		.operation   (operation),
		.color_index (color_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.dst_valid   (dst_valid),
		.dst_ready   (dst_ready),
		.dest_x      (dest_x),
		.dest_y      (dest_y),
		.rgb565      (rgb565),
		.last_of_run (last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int dest_rows_for(int acc);
		if (DST_H <= acc)
			return 0;
		return (DST_H - acc + SRC_H - 1) / SRC_H;
	endfunction

	function automatic void restart_raster();
		raster_col = 0;
		raster_row = 0;
		first_row = 0;
		row_acc = 0;
		rows_here = dest_rows_for(0);
	endfunction

	function automatic void advance_row();
		if (raster_row + 1 >= SRC_H) begin
			restart_raster();
		end else begin
			raster_row++;
			first_row += rows_here;
			row_acc = row_acc + rows_here * SRC_H - DST_H;
			rows_here = dest_rows_for(row_acc);
		end
	endfunction

	function automatic void scale_source_item(logic [1:0] op, logic [7:0] idx,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int emit;
		scaled_pixel_t px;
		case (op)
			OP_PALETTE: begin
				palette[idx] = {r[7:3], g[7:2], b[7:3]};
			end
			OP_RESTART: begin
				restart_raster();
			end
			OP_PIXEL: begin
				emit = (rows_here > 2) ? 2 : rows_here;
				for (int i = 0; i < emit; i++) begin
					px.dest_x = raster_col[8:0];
					px.dest_y = 8'(first_row + i);
					px.rgb565 = palette[idx];
					px.last_of_run = (i + 1 == emit);
					pixels_due.push_back(px);
				end
				raster_col++;
				if (raster_col >= SRC_W) begin
					raster_col = 0;
					advance_row();
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(logic [1:0] op, logic [7:0] idx,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		if ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		src_valid <= 1'b1;
		operation <= op;
		color_index <= idx;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (!src_ready);
		scale_source_item(op, idx, r, g, b);
	endtask

	task automatic send_pixel(logic [7:0] idx);
		send_item(OP_PIXEL, idx, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic wait_for_drain();
		src_valid <= 1'b0;
		do @(posedge clk); while (pixels_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(int src_pct, int dst_pct);
		src_idle_pct = src_pct;
		dst_idle_pct = dst_pct;
	endtask

	task automatic test_unwritten_palette();
		send_pixel(8'd0);
		send_pixel(8'd255);
		wait_for_drain();
	endtask

	task automatic test_palette_extremes();
		send_item(OP_PALETTE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_PALETTE, 8'd255, 8'hF8, 8'h00, 8'h00);
		send_item(OP_PALETTE, 8'd1, 8'h00, 8'hFC, 8'h00);
		send_item(OP_PALETTE, 8'd2, 8'h00, 8'h00, 8'hF8);
		send_item(OP_PALETTE, 8'd3, 8'h07, 8'h03, 8'h07);
		send_item(OP_PALETTE, 8'd4, 8'hAA, 8'h55, 8'hAA);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd1);
		send_pixel(8'd2);
		send_pixel(8'd3);
		send_pixel(8'd4);
		wait_for_drain();
	endtask

	task automatic test_ignored_and_restart();
		send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'd4);
		send_item(OP_RESTART, 8'h5A, 8'hA5, 8'h5A, 8'hA5);
		send_pixel(8'd0);
		send_pixel(8'd255);
		wait_for_drain();
	endtask

	task automatic test_random_stream(int items);
		int sent;
		int pick;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(999);
			if (pick < 850) begin
				send_pixel(8'($urandom));
				sent++;
			end else if (pick < 960) begin
				send_item(OP_PALETTE, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
				sent++;
			end else if (pick < 965) begin
				send_item(OP_RESTART, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
				sent++;
			end else begin
				send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
			end
		end
		wait_for_drain();
	endtask

	task automatic test_output_backpressure();
		set_idling(0, 0);
		hold_req <= ~hold_req;
		for (int i = 0; i < 40; i++)
			send_pixel(8'($urandom));
		wait_for_drain();
	endtask

	task automatic test_row_advance();
		set_idling(0, 0);
		send_item(OP_RESTART, 8'd0, 8'd0, 8'd0, 8'd0);
		for (int i = 0; i < 2 * SRC_W + 4; i++)
			send_pixel(8'($urandom));
		wait_for_drain();
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		scaled_pixel_t want;
		if (arst_n && dst_valid && dst_ready) begin
			if (pixels_due.size() == 0) begin
				mismatches++;
				$display("%0t: no result expected, actual x %0d y %0d rgb %0d last %0d",
					$time, dest_x, dest_y, rgb565, last_of_run);
			end else begin
				want = pixels_due.pop_front();
				check_field("dest_x", want.dest_x, dest_x);
				check_field("dest_y", want.dest_y, dest_y);
				check_field("rgb565", want.rgb565, rgb565);
				check_field("last_of_run", want.last_of_run, last_of_run);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			dst_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			dst_ready <= 1'b0;
		end else begin
			dst_ready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (src_valid && src_ready) || (dst_valid && dst_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < 256; i++)
			palette[i] = '0;
		restart_raster();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(21, 52);
		test_unwritten_palette();
		test_palette_extremes();
		test_ignored_and_restart();

		set_idling(21, 52);
		test_random_stream(240);
		set_idling(52, 21);
		test_random_stream(240);
		set_idling(0, 0);
		test_random_stream(240);

		test_output_backpressure();
		test_row_advance();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
hdl/pup_pkg.sv
hdl/pup_front.sv
hdl/pup_queue.sv
hdl/pup_back.sv
hdl/palette_upscale_rgb565.sv
dv/palette_upscale_rgb565_test.sv
